FILE: src/swbb_pkg.sv
// Shared constants and types for the swept box versus box test.
package swbb_pkg;

    // Default field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 13;

    // Fixed widths of the mover extents
    localparam int MOVER_MIN_W = 13;
    localparam int MOVER_MAX_W = 14;

    // Number of obstacle faces (left, right, near, far)
    localparam int NUM_FACES = 4;

    // Separation margin used by the slab clip
    localparam int EPS_DIST = 1;

    typedef enum logic [1:0] {
        OUT_CLEAR   = 2'd0,
        OUT_BLOCKED = 2'd1,
        OUT_INSIDE  = 2'd2
    } outcome_t;

endpackage

FILE: src/swept_box_vs_box_block_test.sv
// Pipelined swept box versus box test: slab clip with exact ratio compare.
//
//   channel | direction | handshake                  | payload
//   query   | in        | query_valid / query_stall  | start, end, mover extents, obstacle
//   result  | out       | result_valid / result_stall| passes, outcome
//
// Four register stages: face distances, ratio numerators and denominators,
// split partial products, then the cross-multiplied compares and the outcome.
// One item per cycle while result_stall is low; result_valid follows the accepting edge
// through the stage valid registers v1_reg, v2_reg, v3_reg and v4_reg in turn.
// The split multiplies (DW x H and DW x HW, with H = DW/2 and HW = DW - H) set the per-stage depth.
// rst_n clears only the stage valid bits; payload registers carry no reset.
// A stalled result holds; upstream stages keep filling bubbles until full.
module swept_box_vs_box_block_test #(
    parameter int COORD_BITS = swbb_pkg::COORD_BITS_DEF,
    parameter int SIZE_BITS  = swbb_pkg::SIZE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               query_valid,
    output logic                               query_stall,
    input  logic [COORD_BITS-1:0]              start_x,
    input  logic [COORD_BITS-1:0]              start_z,
    input  logic [COORD_BITS-1:0]              end_x,
    input  logic [COORD_BITS-1:0]              end_z,
    input  logic signed [swbb_pkg::MOVER_MIN_W-1:0] mover_min_x,
    input  logic signed [swbb_pkg::MOVER_MIN_W-1:0] mover_min_z,
    input  logic signed [swbb_pkg::MOVER_MAX_W-1:0] mover_max_x,
    input  logic signed [swbb_pkg::MOVER_MAX_W-1:0] mover_max_z,
    input  logic [COORD_BITS-1:0]              obstacle_x,
    input  logic [COORD_BITS-1:0]              obstacle_z,
    input  logic [SIZE_BITS-1:0]               obstacle_size_x,
    input  logic [SIZE_BITS-1:0]               obstacle_size_z,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               passes,
    output swbb_pkg::outcome_t                 outcome
);

    import swbb_pkg::*;

    localparam int M1 = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
    localparam int MW = (M1 > MOVER_MAX_W - 1) ? M1 : MOVER_MAX_W - 1;
    // Signed distance width; also the unsigned width of numerators and denominators
    localparam int DW = MW + 3;
    localparam int H  = DW / 2;
    localparam int HW = DW - H;
    localparam int PW = 2 * DW;

    typedef logic signed [DW-1:0] dist_t;
    typedef logic [DW-1:0]        mag_t;

    // Stage handshake
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign en4 = !v4_reg || !result_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign query_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= query_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: signed separation of each face at start and end of the move
    dist_t sd_next [NUM_FACES];
    dist_t ed_next [NUM_FACES];
    dist_t sd_reg  [NUM_FACES];
    dist_t ed_reg  [NUM_FACES];

    always_comb
    begin
        dist_t sx, sz, ex, ez, mnx, mnz, mxx, mxz;
        dist_t lox, loz, hix, hiz, szx, szz;
        sx  = dist_t'({{(DW - COORD_BITS){1'b0}}, start_x});
        sz  = dist_t'({{(DW - COORD_BITS){1'b0}}, start_z});
        ex  = dist_t'({{(DW - COORD_BITS){1'b0}}, end_x});
        ez  = dist_t'({{(DW - COORD_BITS){1'b0}}, end_z});
        mnx = dist_t'({{(DW - MOVER_MIN_W){mover_min_x[MOVER_MIN_W-1]}}, mover_min_x});
        mnz = dist_t'({{(DW - MOVER_MIN_W){mover_min_z[MOVER_MIN_W-1]}}, mover_min_z});
        mxx = dist_t'({{(DW - MOVER_MAX_W){mover_max_x[MOVER_MAX_W-1]}}, mover_max_x});
        mxz = dist_t'({{(DW - MOVER_MAX_W){mover_max_z[MOVER_MAX_W-1]}}, mover_max_z});
        szx = dist_t'({{(DW - SIZE_BITS){1'b0}}, obstacle_size_x});
        szz = dist_t'({{(DW - SIZE_BITS){1'b0}}, obstacle_size_z});
        // Min edge is centre minus half the size, floored
        lox = dist_t'({{(DW - COORD_BITS){1'b0}}, obstacle_x}) - (szx >>> 1);
        loz = dist_t'({{(DW - COORD_BITS){1'b0}}, obstacle_z}) - (szz >>> 1);
        hix = lox + szx;
        hiz = loz + szz;

        sd_next[0] = lox - (sx + mxx);
        ed_next[0] = lox - (ex + mxx);
        sd_next[1] = (sx + mnx) - hix;
        ed_next[1] = (ex + mnx) - hix;
        sd_next[2] = loz - (sz + mxz);
        ed_next[2] = loz - (ez + mxz);
        sd_next[3] = (sz + mnz) - hiz;
        ed_next[3] = (ez + mnz) - hiz;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sd_reg <= sd_next;
            ed_reg <= ed_next;
        end
    end

    // Stage 2: classify faces and form each ratio as num / den
    logic [NUM_FACES-1:0] inward_next, outward_next, neg_next;
    logic                 bothpos_next, startpos_next;
    mag_t                 num_next [NUM_FACES];
    mag_t                 den_next [NUM_FACES];
    logic [NUM_FACES-1:0] inward_reg, outward_reg, neg_reg;
    logic                 bothpos_reg, startpos_reg;
    mag_t                 num_reg  [NUM_FACES];
    mag_t                 den_reg  [NUM_FACES];

    always_comb
    begin
        logic signed [DW:0] s, e, diff, nm;
        logic               sp, ep;
        bothpos_next  = 1'b0;
        startpos_next = 1'b0;
        for (int i = 0; i < NUM_FACES; i++)
        begin
            s  = {sd_reg[i][DW-1], sd_reg[i]};
            e  = {ed_reg[i][DW-1], ed_reg[i]};
            sp = (sd_reg[i] > 0);
            ep = (ed_reg[i] > 0);
            inward_next[i]  = sp && !ep;
            outward_next[i] = !sp && ep;
            bothpos_next    = bothpos_next | (sp & ep);
            startpos_next   = startpos_next | sp;
            // Exit numerator is -(s + eps), which is -1 when s is zero
            neg_next[i] = !sp && (sd_reg[i] == '0);
            if (sp)
            begin
                diff = s - e;
                nm   = s - (DW+1)'(EPS_DIST);
            end
            else
            begin
                diff = e - s;
                nm   = -s - (DW+1)'(EPS_DIST);
            end
            num_next[i] = nm[DW-1:0];
            den_next[i] = diff[DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            inward_reg   <= inward_next;
            outward_reg  <= outward_next;
            neg_reg      <= neg_next;
            bothpos_reg  <= bothpos_next;
            startpos_reg <= startpos_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
        end
    end

    // Stage 3: num[i] * den[j] in two halves of den
    logic [DW+H-1:0]      pl_next [NUM_FACES][NUM_FACES];
    logic [DW+HW-1:0]     ph_next [NUM_FACES][NUM_FACES];
    logic [NUM_FACES-1:0] lt_one_next;
    logic [DW+H-1:0]      pl_reg  [NUM_FACES][NUM_FACES];
    logic [DW+HW-1:0]     ph_reg  [NUM_FACES][NUM_FACES];
    logic [NUM_FACES-1:0] lt_one_reg;
    logic [NUM_FACES-1:0] inward3_reg, outward3_reg, neg3_reg;
    logic                 bothpos3_reg, startpos3_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_FACES; i++)
        begin
            // Entry ratio below the default exit of one
            lt_one_next[i] = num_reg[i] < den_reg[i];
            for (int j = 0; j < NUM_FACES; j++)
            begin
                pl_next[i][j] = (DW+H)'(num_reg[i]) * (DW+H)'(den_reg[j][H-1:0]);
                ph_next[i][j] = (DW+HW)'(num_reg[i]) * (DW+HW)'(den_reg[j][DW-1:H]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            pl_reg        <= pl_next;
            ph_reg        <= ph_next;
            lt_one_reg    <= lt_one_next;
            inward3_reg   <= inward_reg;
            outward3_reg  <= outward_reg;
            neg3_reg      <= neg_reg;
            bothpos3_reg  <= bothpos_reg;
            startpos3_reg <= startpos_reg;
        end
    end

    // Stage 4: a block needs every entry ratio below every exit ratio; the outcome is then chosen
    outcome_t outcome_next;
    outcome_t outcome_reg;

    always_comb
    begin
        logic [PW-1:0]        prod [NUM_FACES][NUM_FACES];
        logic [NUM_FACES-1:0] ok;
        logic                 blocked;
        for (int i = 0; i < NUM_FACES; i++)
        begin
            for (int j = 0; j < NUM_FACES; j++)
            begin
                prod[i][j] = PW'(pl_reg[i][j]) + (PW'(ph_reg[i][j]) << H);
            end
        end
        blocked = |inward3_reg;
        for (int i = 0; i < NUM_FACES; i++)
        begin
            ok[i] = lt_one_reg[i];
            for (int j = 0; j < NUM_FACES; j++)
            begin
                // A negative exit can never exceed a non-negative entry
                if (outward3_reg[j] && (neg3_reg[j] || !(prod[i][j] < prod[j][i])))
                begin
                    ok[i] = 1'b0;
                end
            end
            if (inward3_reg[i] && !ok[i])
            begin
                blocked = 1'b0;
            end
        end

        if (bothpos3_reg)
        begin
            outcome_next = OUT_CLEAR;
        end
        else if (!startpos3_reg)
        begin
            outcome_next = OUT_INSIDE;
        end
        else if (blocked)
        begin
            outcome_next = OUT_BLOCKED;
        end
        else
        begin
            outcome_next = OUT_CLEAR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            outcome_reg <= outcome_next;
        end
    end

    assign result_valid = v4_reg;
    assign outcome      = outcome_reg;
    assign passes       = (outcome_reg == OUT_CLEAR);

endmodule

FILE: src/swbb_check.sv
// Port-level assertions for the swept box test, bound to the top level.
module swbb_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_valid,
    input  logic               query_stall,
    input  logic               result_valid,
    input  logic               result_stall,
    input  logic               passes,
    input  swbb_pkg::outcome_t outcome
);

    import swbb_pkg::*;

    // Only a clear outcome lets the move pass
    a_pass_matches_outcome: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (passes == (outcome == OUT_CLEAR))
    ) else $error("passes disagrees with outcome");

    // Back-pressure on queries only when a finished result is held
    a_stall_from_full_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        query_stall |-> (result_valid && result_stall)
    ) else $error("query stalled while result side is free");

    // Leave reset empty and ready for an item
    a_empty_after_reset: assert property (
        @(posedge clk)
        $rose(rst_n) |-> (!result_valid && !query_stall)
    ) else $error("block not empty right after reset");

    // A stalled result holds
    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(passes) && $stable(outcome))
    ) else $error("stalled result changed");

endmodule

bind swept_box_vs_box_block_test swbb_check u_swbb_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .passes       (passes),
    .outcome      (outcome)
);
